// File: design/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg - shared types and helpers for the PPP async deframer
// Octet codes, queue entry layout and the per-octet frame bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

    localparam logic [7:0]  FLAG_OCTET    = 8'h7E;
    localparam logic [7:0]  ESC_OCTET     = 8'h7D;
    localparam logic [7:0]  ESC_MASK      = 8'h20;
    localparam logic [7:0]  ESC_KEEP_HI   = 8'h5E;
    localparam logic [7:0]  ESC_KEEP_LO   = 8'h5D;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [15:0] PROTO_RESET   = 16'h8021;
    localparam logic [15:0] IDX_PROTO_HI  = 16'd2;
    localparam logic [15:0] IDX_PROTO_LO  = 16'd3;
    localparam logic [15:0] MIN_PROTO_LEN = 16'd4;
    localparam int          QUEUE_DEPTH   = 4;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
        logic [15:0] protocol_word;
        logic        protocol_match;
    } result_t;

    // One accepted octet gives one or two results
    typedef struct packed {
        logic    two;
        result_t res0;
        result_t res1;
    } entry_t;

    typedef struct packed {
        logic [15:0] cnt;
        logic [7:0]  ph;
        logic [7:0]  pl;
    } frame_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Advance frame bookkeeping by one payload octet
    function automatic frame_state_t ppd_emit(frame_state_t s, logic [7:0] b);
        frame_state_t r;
        r = s;
        if (s.cnt == IDX_PROTO_HI) r.ph = b;
        if (s.cnt == IDX_PROTO_LO) r.pl = b;
        if (s.cnt != COUNT_MAX) r.cnt = s.cnt + 16'd1;
        return r;
    endfunction

    function automatic result_t ppd_byte_res(logic [7:0] b, logic [15:0] idx);
        result_t r;
        r                = '0;
        r.kind           = KIND_BYTE;
        r.data_byte      = b;
        r.byte_index     = idx;
        return r;
    endfunction

    function automatic result_t ppd_eof_res(frame_state_t s, logic [15:0] proto);
        result_t     r;
        logic [15:0] word;
        word             = (s.cnt >= MIN_PROTO_LEN) ? {s.ph, s.pl} : 16'd0;
        r                = '0;
        r.kind           = KIND_EOF;
        r.frame_length   = s.cnt;
        r.protocol_word  = word;
        r.protocol_match = (word == proto);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/ppp_async_deframer.sv
// ----------------------------------------------------------------------------
// ppp_async_deframer - PPP HDLC-like asynchronous deframer
// Removes flags and escapes, reports payload octets and end-of-frame summaries.
// ----------------------------------------------------------------------------
//
//  channel | signals                              | direction | handshake
//  --------+--------------------------------------+-----------+-----------
//  input   | rx_byte                              | in        | in_valid/in_ready
//  output  | kind data_byte byte_index            | out       | out_valid/out_ready
//          | frame_length protocol_word           |           |
//          | protocol_match last                  |           |
//  config  | cfg_wr_data (match_protocol)         | in        | cfg_wr_en, no wait
//
//  One octet is accepted per cycle while the entry queue has room; the front
//  part classifies it in the same cycle, so octets follow back to back.
//  Results leave one per cycle while out_ready is high; an octet that yields
//  two results holds the output until both are taken, and the queue of DEPTH
//  entries absorbs that. Each accepted entry is registered in the queue first.
//  Reset clears state at once; no clearing pass, hunting for a flag after it.
//  Either side may stall on its own: a full queue drops in_ready, an empty
//  queue drops out_valid; a stalled result holds until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_async_deframer
    import ppd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [7:0]       data_byte,
    output logic [15:0]      byte_index,
    output logic [15:0]      frame_length,
    output logic [15:0]      protocol_word,
    output logic             protocol_match,
    output logic             last,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    q_status_t q_status;
    logic      push, pop;
    entry_t    push_entry, head;
    result_t   out_res;

    // front: accept, track frame state, classify each octet
    ppd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // queue: decouple front from back
    ppd_queue #(
        .DEPTH(DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    // back: deliver results one request at a time
    ppd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_res  (out_res),
        .last     (last)
    );

    assign kind           = out_res.kind;
    assign data_byte      = out_res.data_byte;
    assign byte_index     = out_res.byte_index;
    assign frame_length   = out_res.frame_length;
    assign protocol_word  = out_res.protocol_word;
    assign protocol_match = out_res.protocol_match;

endmodule

`default_nettype wire

// File: design/ppd_front.sv
// ----------------------------------------------------------------------------
// ppd_front - octet acceptance and classification
// Tracks hunt/escape/frame state and pushes one queue entry per octet that yields results.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_front
    import ppd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire q_status_t   q_status,
    output logic             push,
    output entry_t           push_entry
);

    logic         hunting_reg, hunting_next;
    logic         esc_reg, esc_next;
    frame_state_t fs_reg, fs_next;
    logic [15:0]  proto_reg;

    logic         accept;
    logic [1:0]   n_emit;
    logic [7:0]   e0, e1;
    frame_state_t s1, s2, s_end;
    result_t      r_e0, r_e1, r_eof;
    logic         eof_valid;
    logic         is_flag;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign is_flag  = (rx_byte == FLAG_OCTET);

    always_comb
    begin
        logic [7:0] t;
        t        = rx_byte ^ ESC_MASK;
        n_emit   = 2'd0;
        e0       = rx_byte;
        e1       = rx_byte;
        esc_next = esc_reg;
        if (is_flag)
        begin
            // pending escape before a flag passes through as the escape octet
            if (esc_reg)
            begin
                n_emit = 2'd1;
                e0     = ESC_OCTET;
            end
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            if (t < ESC_MASK || rx_byte == ESC_KEEP_HI || rx_byte == ESC_KEEP_LO)
            begin
                n_emit = 2'd1;
                e0     = t;
            end
            else
            begin
                n_emit = 2'd2;
                e0     = ESC_OCTET;
            end
        end
        else if (rx_byte == ESC_OCTET)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            n_emit = 2'd1;
        end
    end

    always_comb
    begin
        s1    = ppd_emit(fs_reg, e0);
        s2    = ppd_emit(s1, e1);
        case (n_emit)
            2'd0:    s_end = fs_reg;
            2'd1:    s_end = s1;
            default: s_end = s2;
        endcase
        r_e0      = ppd_byte_res(e0, fs_reg.cnt);
        r_e1      = ppd_byte_res(e1, s1.cnt);
        r_eof     = ppd_eof_res(s_end, proto_reg);
        eof_valid = is_flag && (s_end.cnt != 16'd0);
    end

    always_comb
    begin
        push_entry.two  = 1'b0;
        push_entry.res0 = r_e0;
        push_entry.res1 = r_e1;
        if (n_emit == 2'd2)
        begin
            push_entry.two = 1'b1;
        end
        else if (n_emit == 2'd1)
        begin
            push_entry.two  = eof_valid;
            push_entry.res1 = r_eof;
        end
        else
        begin
            push_entry.res0 = r_eof;
        end
        push = accept && !hunting_reg && (n_emit != 2'd0 || eof_valid);
    end

    always_comb
    begin
        hunting_next = hunting_reg;
        fs_next      = fs_reg;
        if (accept)
        begin
            if (is_flag)
            begin
                // a flag closes any frame and opens the next one
                hunting_next = 1'b0;
                fs_next      = '0;
            end
            else if (!hunting_reg)
            begin
                fs_next = s_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg <= 1'b1;
            esc_reg     <= 1'b0;
            fs_reg      <= '0;
            proto_reg   <= PROTO_RESET;
        end
        else
        begin
            hunting_reg <= hunting_next;
            fs_reg      <= fs_next;
            if (accept)
            begin
                esc_reg <= (is_flag || hunting_reg) ? 1'b0 : esc_next;
            end
            if (cfg_wr_en)
            begin
                proto_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/ppd_queue.sv
// ----------------------------------------------------------------------------
// ppd_queue - entry queue between front and back
// Small circular buffer of classified entries.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_queue
    import ppd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      head,
    output q_status_t   q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign q_status.full  = (cnt_reg == CNT_FULL);
    assign q_status.empty = (cnt_reg == '0);
    assign head           = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/ppd_back.sv
// ----------------------------------------------------------------------------
// ppd_back - result sequencer
// Delivers the one or two results of the head entry, then releases it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_back
    import ppd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire entry_t    head,
    input  wire q_status_t q_status,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output result_t        out_res,
    output logic           last
);

    logic sel_reg;
    logic out_accept;

    assign out_valid  = !q_status.empty;
    assign out_res    = sel_reg ? head.res1 : head.res0;
    assign last       = sel_reg || !head.two;
    assign out_accept = out_valid && out_ready;
    assign pop        = out_accept && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else if (out_accept)
        begin
            sel_reg <= !last;
        end
    end

endmodule

`default_nettype wire

// File: design/ppd_checker.sv
// ----------------------------------------------------------------------------
// ppd_checker - port-level checks for the PPP async deframer
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_checker
    import ppd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        kind,
    input wire logic [7:0]  data_byte,
    input wire logic [15:0] byte_index,
    input wire logic [15:0] frame_length,
    input wire logic [15:0] protocol_word,
    input wire logic        protocol_match,
    input wire logic        last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind)
            && $stable(data_byte) && $stable(byte_index) && $stable(last))
        else $error("stalled result changed");

    // a summary always closes the octet's results
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EOF |-> last)
        else $error("summary not marked last");

    a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE |->
            frame_length == 16'd0 && protocol_word == 16'd0 && !protocol_match)
        else $error("payload result carries summary fields");

    a_eof_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EOF |->
            data_byte == 8'd0 && byte_index == 16'd0 && frame_length != 16'd0)
        else $error("bad summary fields");

endmodule

bind ppp_async_deframer ppd_checker u_ppd_checker (.*);

`default_nettype wire

// File: tb/ppd_deframe_checker.sv
// ----------------------------------------------------------------------------
// ppd_deframe_checker - result checker for the PPP async deframer
// Tracks accepted octets and register writes, predicts the payload and
// end-of-frame results, and compares every accepted result in order.
// ----------------------------------------------------------------------------

module ppd_deframe_checker
    import ppd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    input  logic [15:0] byte_index,
    input  logic [15:0] frame_length,
    input  logic [15:0] protocol_word,
    input  logic        protocol_match,
    input  logic        last,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
        logic [15:0] protocol_word;
        logic        protocol_match;
        logic        last;
    } deframed_t;

    // Predicted deframer state
    logic        seeking_flag;
    logic        esc_seen;
    logic [15:0] octet_count;
    logic [7:0]  proto_hi;
    logic [7:0]  proto_lo;
    logic [15:0] flag_protocol;

    deframed_t   pending_results[$];
    deframed_t   want;

    function automatic void start_frame();
        seeking_flag = 1'b0;
        esc_seen     = 1'b0;
        octet_count  = '0;
        proto_hi     = '0;
        proto_lo     = '0;
    endfunction

    // Record one payload octet and advance the frame counters
    function automatic deframed_t take_payload(input logic [7:0] b);
        deframed_t r;
        r            = '0;
        r.kind       = KIND_BYTE;
        r.data_byte  = b;
        r.byte_index = octet_count;
        if (octet_count == IDX_PROTO_HI)
            proto_hi = b;
        if (octet_count == IDX_PROTO_LO)
            proto_lo = b;
        if (octet_count != COUNT_MAX)
            octet_count = octet_count + 16'd1;
        return r;
    endfunction

    task automatic deframe_octet(input logic [7:0] b);
        deframed_t   res [2];
        int          n;
        int          i;
        logic [7:0]  t;
        logic [15:0] word;
        n = 0;
        if (seeking_flag)
        begin
            if (b == FLAG_OCTET)
                start_frame();
        end
        else if (b == FLAG_OCTET)
        begin
            if (esc_seen)
            begin
                res[n] = take_payload(ESC_OCTET);
                n = n + 1;
            end
            if (octet_count != 0)
            begin
                word = (octet_count >= MIN_PROTO_LEN) ? {proto_hi, proto_lo} : 16'd0;
                res[n]                = '0;
                res[n].kind           = KIND_EOF;
                res[n].frame_length   = octet_count;
                res[n].protocol_word  = word;
                res[n].protocol_match = (word == flag_protocol);
                n = n + 1;
            end
            start_frame();
        end
        else if (esc_seen)
        begin
            t        = b ^ ESC_MASK;
            esc_seen = 1'b0;
            if (t < ESC_MASK || b == ESC_KEEP_HI || b == ESC_KEEP_LO)
            begin
                res[n] = take_payload(t);
                n = n + 1;
            end
            else
            begin
                res[0] = take_payload(ESC_OCTET);
                res[1] = take_payload(b);
                n = 2;
            end
        end
        else if (b == ESC_OCTET)
        begin
            esc_seen = 1'b1;
        end
        else
        begin
            res[n] = take_payload(b);
            n = n + 1;
        end
        if (n > 0)
            res[n - 1].last = 1'b1;
        for (i = 0; i < n; i++)
            pending_results.push_back(res[i]);
    endtask

    task automatic note_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
        mismatches++;
        $display("mismatch at %0t: %s got %h, expected %h", $realtime, what, got,
                 exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeking_flag  = 1'b1;
            esc_seen      = 1'b0;
            octet_count   = '0;
            proto_hi      = '0;
            proto_lo      = '0;
            flag_protocol = PROTO_RESET;
            mismatches    = 0;
            pending_results.delete();
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                flag_protocol = cfg_wr_data;
            if (in_valid && in_ready)
                deframe_octet(rx_byte);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    note_mismatch("result with nothing expected, data_byte",
                                  {8'h00, data_byte}, 16'h0000);
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind)
                        note_mismatch("kind", 16'(kind), 16'(want.kind));
                    if (data_byte !== want.data_byte)
                        note_mismatch("data_byte", 16'(data_byte), 16'(want.data_byte));
                    if (byte_index !== want.byte_index)
                        note_mismatch("byte_index", byte_index, want.byte_index);
                    if (frame_length !== want.frame_length)
                        note_mismatch("frame_length", frame_length, want.frame_length);
                    if (protocol_word !== want.protocol_word)
                        note_mismatch("protocol_word", protocol_word, want.protocol_word);
                    if (protocol_match !== want.protocol_match)
                        note_mismatch("protocol_match", 16'(protocol_match),
                                      16'(want.protocol_match));
                    if (last !== want.last)
                        note_mismatch("last", 16'(last), 16'(want.last));
                end
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// File: tb/ppp_async_deframer_tb.sv
// ----------------------------------------------------------------------------
// ppp_async_deframer_tb - testbench top for the PPP async deframer
// Feeds flag-delimited, byte-stuffed octet streams under changing idle
// patterns and protocol settings; a checker beside the block scores results.
// ----------------------------------------------------------------------------

module ppp_async_deframer_tb;

    import ppd_pkg::*;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [7:0]  rx_byte     = 8'h00;
    logic        out_ready   = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    logic        in_ready;
    logic        out_valid;
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic [15:0] protocol_word;
    logic        protocol_match;
    logic        last;

    int          fail_count;
    int          outstanding;

    // Idle percentages, changed between phases
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    // Set by the stimulus to ask the receiver for one long hold-off
    bit          stall_armed   = 1'b0;
    int          stall_left;
    int          sent_count    = 0;
    // Protocol number currently programmed, used to build matching frames
    logic [15:0] match_now     = PROTO_RESET;

    // Opening stream: noise while hunting, an empty frame, a frame carrying the
    // default protocol, every escape flavor, and an escape right before a flag
    logic [7:0]  opening_seq [0:21];

    always #5 clk = ~clk;

    ppp_async_deframer uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .frame_length   (frame_length),
        .protocol_word  (protocol_word),
        .protocol_match (protocol_match),
        .last           (last),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    ppd_deframe_checker deframe_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .frame_length   (frame_length),
        .protocol_word  (protocol_word),
        .protocol_match (protocol_match),
        .last           (last),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatches     (fail_count),
        .outstanding    (outstanding)
    );

    // Receiver: drop ready at random, or hold it low for a long stretch on
    // request so the entry queue fills and the input side stalls.
    initial
    begin
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_armed)
            begin
                stall_armed = 1'b0;
                stall_left  = 120;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one octet, idling first at random; return at the accepting edge
    // with valid still high, so the caller either follows on or drops it.
    task automatic send_octet(input logic [7:0] octet);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= octet;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    // Stop offering and wait until every expected result has been taken, then
    // give the block a few more cycles in case a result-free octet is in flight.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_match(input logic [15:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        match_now    = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Send one frame body of len octets plus its closing flag. Flags and escape
    // octets in the body are stuffed, control octets only sometimes. Unless
    // tidy, add stray escapes that are not undone and an escape before the flag.
    task automatic send_frame(input int len, input bit tidy);
        logic [7:0] b;
        bit         hit;
        int         i;
        int         r;
        hit = ($urandom_range(2) == 0);
        for (i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(255));
            if ($urandom_range(7) == 0)
            begin
                case ($urandom_range(5))
                    0: b = FLAG_OCTET;
                    1: b = ESC_OCTET;
                    2: b = 8'h00;
                    3: b = 8'h1F;
                    4: b = ESC_KEEP_HI;
                    default: b = 8'hFF;
                endcase
            end
            // Place the programmed protocol at octets 2 and 3 to hit the match
            if (hit && i == 2)
                b = match_now[15:8];
            if (hit && i == 3)
                b = match_now[7:0];
            r = tidy ? 1 : $urandom_range(19);
            if (r == 0)
            begin
                send_octet(ESC_OCTET);
                send_octet(8'($urandom_range(255)));
            end
            if (b == FLAG_OCTET || b == ESC_OCTET || (b < ESC_MASK && $urandom_range(1) == 0))
            begin
                send_octet(ESC_OCTET);
                send_octet(b ^ ESC_MASK);
            end
            else
                send_octet(b);
        end
        if (!tidy && $urandom_range(9) == 0)
            send_octet(ESC_OCTET);
        send_octet(FLAG_OCTET);
    endtask

    // Send random frames, mostly short, until about n more octets have gone in
    task automatic fill_frames(input int n);
        int goal;
        int r;
        int len;
        goal = sent_count + n;
        while (sent_count < goal)
        begin
            r = $urandom_range(99);
            if (r < 6)
                len = 0;
            else if (r < 85)
                len = $urandom_range(8, 1);
            else
                len = $urandom_range(40, 9);
            send_frame(len, 1'b0);
        end
    endtask

    initial
    begin
        opening_seq = '{8'h00, ESC_OCTET, 8'hFF, FLAG_OCTET, FLAG_OCTET,
                        8'hFF, 8'h03, 8'h80, 8'h21,
                        ESC_OCTET, 8'h3F, 8'h00,
                        ESC_OCTET, ESC_KEEP_HI, ESC_OCTET, ESC_KEEP_LO,
                        ESC_OCTET, 8'h41, ESC_OCTET, 8'h00,
                        ESC_OCTET, FLAG_OCTET};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset protocol
        foreach (opening_seq[i])
            send_octet(opening_seq[i]);

        // One-octet frame: word is zero and matches a zero protocol
        set_match(16'h0000);
        send_octet(8'h12);
        send_octet(FLAG_OCTET);

        // Slow sender, slower receiver
        send_idle_pct = 22;
        recv_idle_pct = 77;
        set_match(16'($urandom_range(65535)));
        fill_frames(500);

        // Slow sender, quick receiver
        send_idle_pct = 77;
        recv_idle_pct = 22;
        set_match(16'hFFFF);
        fill_frames(500);

        // No idling; open with a long receiver hold-off under a steady stream
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_match(16'($urandom_range(65535)));
        stall_armed = 1'b1;
        send_frame(48, 1'b1);
        fill_frames(360);

        settle();
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard limit, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
